// File: rtl/rsab26_pkg.sv
// ============================================================================
// rsab26_pkg
// Shared types and constants for the base-26 block encryptor.
// ============================================================================
package rsab26_pkg;

    localparam int unsigned DEF_MODULUS_BITS      = 32;
    localparam int unsigned DEF_MAX_BLOCK_LETTERS = 6;

    localparam int unsigned PLAIN_W  = 29;
    localparam int unsigned CIPHER_W = 32;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned LEN_W    = 3;
    localparam int unsigned IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_MODULUS  = 2'd0;
    localparam logic [IDX_W-1:0] REG_EXPONENT = 2'd1;
    localparam logic [IDX_W-1:0] REG_BLOCKLEN = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'd65;
    localparam logic [CHAR_W-1:0] RADIX      = 8'd26;

    localparam logic [CFG_W-1:0]   RST_MODULUS  = 32'd3233;
    localparam logic [CFG_W-1:0]   RST_EXPONENT = 32'd17;
    localparam logic [LEN_W-1:0]   RST_BLOCKLEN = 3'd2;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,      // load base, exponent and product = 1 mod n
        OP_MUL_PROD,  // start product * square
        OP_MUL_SQR,   // start square * square
        OP_SHIFT      // drop one exponent bit
    } op_t;

    // Controller to datapath command.
    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic mod_busy;
        logic exp_zero;
        logic exp_lsb;
    } dp_stat_t;

endpackage

// File: rtl/rsab26_modmul.sv
// ============================================================================
// rsab26_modmul
// Multi-cycle modular multiplier: registered product, then a restoring
// remainder reduction of one bit per cycle.
// ============================================================================
module rsab26_modmul #(
    parameter int unsigned MODULUS_BITS = 32,
    parameter int unsigned A_W          = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [A_W-1:0]          op_a,
    input  logic [MODULUS_BITS-1:0] op_b,
    input  logic [MODULUS_BITS-1:0] modulus,
    output logic                    busy,
    output logic [MODULUS_BITS-1:0] result
);
    localparam int unsigned PW = A_W + MODULUS_BITS;
    localparam int unsigned CW = $clog2(PW + 1);

    logic [PW-1:0]           prod_reg, prod_next;
    logic [MODULUS_BITS:0]   rem_reg, rem_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    mul_reg, mul_next;
    logic                    busy_reg, busy_next;
    logic [MODULUS_BITS+1:0] trial;

    // Shift in the next product bit and subtract the modulus when it fits.
    always_comb begin
        prod_next = prod_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        mul_next  = 1'b0;
        busy_next = busy_reg;
        trial     = {rem_reg, prod_reg[PW-1]};
        if (start) begin
            prod_next = PW'(op_a) * PW'(op_b);
            mul_next  = 1'b1;
            busy_next = 1'b1;
            rem_next  = '0;
            cnt_next  = CW'(PW);
        end else if (busy_reg && !mul_reg) begin
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                prod_next = {prod_reg[PW-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (trial >= {2'b00, modulus}) begin
                    rem_next = (MODULUS_BITS+1)'(trial - {2'b00, modulus});
                end else begin
                    rem_next = (MODULUS_BITS+1)'(trial);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            mul_reg  <= mul_next;
        end
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    assign busy   = busy_reg;
    assign result = rem_reg[MODULUS_BITS-1:0];

endmodule

// File: rtl/rsab26_datapath.sv
// ============================================================================
// rsab26_datapath
// Holds the exponentiation registers and the shared modular multiplier.
// ============================================================================
module rsab26_datapath #(
    parameter int unsigned MODULUS_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rsab26_pkg::dp_cmd_t               cmd,
    input  logic [rsab26_pkg::PLAIN_W-1:0]    base,
    input  logic [rsab26_pkg::CFG_W-1:0]      exponent,
    input  logic [MODULUS_BITS-1:0]           modulus,
    output rsab26_pkg::dp_stat_t              stat,
    output logic [rsab26_pkg::CIPHER_W-1:0]   cipher
);
    import rsab26_pkg::*;

    localparam int unsigned MB = MODULUS_BITS;
    // The first operand must hold a whole plain block as well as a residue.
    localparam int unsigned AW = (MB > PLAIN_W) ? MB : PLAIN_W;

    logic [MB-1:0]    prod_reg, prod_next;
    logic [MB-1:0]    sqr_reg, sqr_next;
    logic [CFG_W-1:0] exp_reg, exp_next;
    logic [1:0]       dst_reg, dst_next;   // bit0: product, bit1: square
    logic             mm_start, mm_busy, mm_busy_q;
    logic [AW-1:0]    mm_a;
    logic [MB-1:0]    mm_b, mm_res;
    logic [MB-1:0]    one_mod;

    // One mod n is zero only when n is one; n of zero is handled the same.
    assign one_mod = (modulus <= MB'(1)) ? '0 : MB'(1);

    assign mm_start = (cmd.op == OP_MUL_PROD) || (cmd.op == OP_MUL_SQR) ||
                      (cmd.op == OP_LOAD);
    assign mm_a = (cmd.op == OP_LOAD) ? AW'(base) :
                  (cmd.op == OP_MUL_PROD) ? AW'(prod_reg) : AW'(sqr_reg);
    assign mm_b = (cmd.op == OP_LOAD) ? MB'(1) : sqr_reg;

    rsab26_modmul #(.MODULUS_BITS(MB), .A_W(AW)) u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (modulus),
        .busy    (mm_busy),
        .result  (mm_res)
    );

    // Commands update the exponent; multiplier results land on completion.
    always_comb begin
        prod_next = prod_reg;
        sqr_next  = sqr_reg;
        exp_next  = exp_reg;
        dst_next  = dst_reg;
        unique case (cmd.op)
            OP_LOAD: begin
                prod_next = one_mod;
                exp_next  = exponent;
                dst_next  = 2'b10;
            end
            OP_MUL_PROD: dst_next = 2'b01;
            OP_MUL_SQR:  dst_next = 2'b10;
            OP_SHIFT:    exp_next = exp_reg >> 1;
            default: ;
        endcase
        if (mm_busy_q && !mm_busy) begin
            if (dst_reg[0]) prod_next = mm_res;
            if (dst_reg[1]) sqr_next  = mm_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mm_busy_q <= 1'b0;
            dst_reg   <= '0;
        end else begin
            mm_busy_q <= mm_busy;
            dst_reg   <= dst_next;
        end
        prod_reg <= prod_next;
        sqr_reg  <= sqr_next;
        exp_reg  <= exp_next;
    end

    // Modulus zero gives zero; any other case the product register.
    assign stat.mod_busy = mm_busy || mm_start;
    assign stat.exp_zero = (exp_reg == '0);
    assign stat.exp_lsb  = exp_reg[0];
    assign cipher = (modulus == '0) ? '0 : CIPHER_W'(prod_reg);

endmodule

// File: rtl/rsab26_ctrl.sv
// ============================================================================
// rsab26_ctrl
// Controller: character parsing, block packing, exponentiation sequencing
// and the output word register.
// ============================================================================
module rsab26_ctrl #(
    parameter int unsigned MAX_BLOCK_LETTERS = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rsab26_pkg::CHAR_W-1:0]     in_char,
    input  logic                              in_last,
    input  logic [rsab26_pkg::LEN_W-1:0]      block_length,
    output rsab26_pkg::dp_cmd_t               cmd,
    input  rsab26_pkg::dp_stat_t              stat,
    output logic [rsab26_pkg::PLAIN_W-1:0]    base,
    input  logic [rsab26_pkg::CIPHER_W-1:0]   cipher,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rsab26_pkg::PLAIN_W-1:0]    out_plain,
    output logic [rsab26_pkg::CIPHER_W-1:0]   out_cipher,
    output logic                              out_bad
);
    import rsab26_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_TEST, S_WAIT_P, S_SQR, S_WAIT_S, S_SHIFT, S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [PLAIN_W-1:0]   acc_reg, acc_next;
    logic [LEN_W-1:0]     cnt_reg, cnt_next;
    logic                 ov_reg, ov_next;
    logic [PLAIN_W-1:0]   op_reg, op_next;
    logic [CIPHER_W-1:0]  oc_reg, oc_next;
    logic                 ob_reg, ob_next;
    op_t                  cmd_op_reg, cmd_op_next;
    logic [LEN_W-1:0]     eff_len, cnt_inc;
    logic [PLAIN_W+4:0]   acc_mul;
    logic                 is_letter, accept;

    // Effective block length after clamping.
    always_comb begin
        eff_len = block_length;
        if (eff_len == '0) eff_len = LEN_W'(1);
        if (eff_len > LEN_W'(MAX_BLOCK_LETTERS)) eff_len = LEN_W'(MAX_BLOCK_LETTERS);
    end

    assign is_letter = (in_char >= CHAR_A) && (in_char < CHAR_A + RADIX);
    assign acc_mul   = (PLAIN_W+5)'(acc_reg) * (PLAIN_W+5)'(RADIX)
                     + (PLAIN_W+5)'(in_char - CHAR_A);
    assign cnt_inc   = cnt_reg + 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign accept    = in_valid && in_ready;

    always_comb begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        ov_next     = ov_reg;
        op_next     = op_reg;
        oc_next     = oc_reg;
        ob_next     = ob_reg;
        cmd_op_next = OP_NONE;
        if (ov_reg && out_ready) ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_char == CHAR_SPACE) begin
                        if (in_last) begin
                            acc_next = '0;
                            cnt_next = '0;
                        end
                    end else if (is_letter) begin
                        acc_next = acc_mul[PLAIN_W-1:0];
                        cnt_next = cnt_inc;
                        if (cnt_inc >= eff_len) begin
                            op_next     = acc_mul[PLAIN_W-1:0];
                            cmd_op_next = OP_LOAD;
                            state_next  = S_LOAD;
                        end else if (in_last) begin
                            acc_next = '0;
                            cnt_next = '0;
                        end
                    end else begin
                        ov_next = 1'b1;
                        op_next = '0;
                        oc_next = '0;
                        ob_next = 1'b1;
                        if (in_last) begin
                            acc_next = '0;
                            cnt_next = '0;
                        end
                    end
                end
            end
            S_LOAD: if (!stat.mod_busy) state_next = S_TEST;
            S_TEST: begin
                if (stat.exp_zero) begin
                    state_next = S_DONE;
                end else if (stat.exp_lsb) begin
                    cmd_op_next = OP_MUL_PROD;
                    state_next  = S_WAIT_P;
                end else begin
                    cmd_op_next = OP_MUL_SQR;
                    state_next  = S_WAIT_S;
                end
            end
            S_WAIT_P: if (!stat.mod_busy) state_next = S_SQR;
            S_SQR: begin
                cmd_op_next = OP_MUL_SQR;
                state_next  = S_WAIT_S;
            end
            S_WAIT_S: begin
                if (!stat.mod_busy) begin
                    cmd_op_next = OP_SHIFT;
                    state_next  = S_SHIFT;
                end
            end
            // The exponent shifts at the end of this cycle, before the next test.
            S_SHIFT: state_next = S_TEST;
            S_DONE: begin
                if (!ov_reg || out_ready) begin
                    ov_next    = 1'b1;
                    oc_next    = cipher;
                    ob_next    = 1'b0;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State, packing registers, the command register and the output word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            ov_reg     <= 1'b0;
            cmd_op_reg <= OP_NONE;
        end else begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            ov_reg     <= ov_next;
            cmd_op_reg <= cmd_op_next;
        end
        op_reg <= op_next;
        oc_reg <= oc_next;
        ob_reg <= ob_next;
    end

    assign cmd.op     = cmd_op_reg;
    assign base       = op_reg;
    assign out_valid  = ov_reg;
    assign out_plain  = op_reg;
    assign out_cipher = oc_reg;
    assign out_bad    = ob_reg;

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_bad |-> out_plain == '0 && out_cipher == '0)
        else $error("bad word carries data");
    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !in_ready)
        else $error("ready during exponentiation");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LEN_W'(MAX_BLOCK_LETTERS))
        else $error("letter count out of range");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_cipher))
        else $error("result word dropped");

endmodule

// File: rtl/rsa_base26_block_encryptor.sv
// ============================================================================
// rsa_base26_block_encryptor
// Packs letters into base-26 blocks and encrypts each block by
// right-to-left square-and-multiply modulo a configured modulus.
// ============================================================================
// Channel  | Ports               | Contents
// ---------+---------------------+------------------------------------------
// input    | s_tvalid/tready     | tdata = character, tlast = end_of_message
// output   | m_tvalid/tready     | tdata = plain_block, cipher_block; tuser = bad
// config   | cfg_we/idx/data     | 0 modulus, 1 public_exponent, 2 block_length
//
// Letters and spaces are taken only in the idle state. A completing letter
// starts an exponentiation: each multiply is a product followed by a
// one-bit-per-cycle reduction over the product width. A set exponent bit costs
// a product multiply and a square, a clear one only a square.
// Reset is synchronous and active low. The result word waits in an output
// register; a stalled output blocks new input only when that register is full.
module rsa_base26_block_encryptor #(
    parameter int unsigned MODULUS_BITS      = rsab26_pkg::DEF_MODULUS_BITS,
    parameter int unsigned MAX_BLOCK_LETTERS = rsab26_pkg::DEF_MAX_BLOCK_LETTERS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] character
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,   // [28:0] plain, [60:29] cipher
    output logic                        m_tuser,   // [0] bad_character
    input  logic                        cfg_we,
    input  logic [rsab26_pkg::IDX_W-1:0] cfg_idx,
    input  logic [rsab26_pkg::CFG_W-1:0] cfg_data
);
    import rsab26_pkg::*;

    logic [CFG_W-1:0]   mod_reg, exp_reg;
    logic [LEN_W-1:0]   len_reg;
    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [PLAIN_W-1:0] base, plain;
    logic [CIPHER_W-1:0] cipher, cipher_o;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= RST_MODULUS;
            exp_reg <= RST_EXPONENT;
            len_reg <= RST_BLOCKLEN;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_MODULUS:  mod_reg <= cfg_data;
                REG_EXPONENT: exp_reg <= cfg_data;
                REG_BLOCKLEN: len_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    rsab26_ctrl #(.MAX_BLOCK_LETTERS(MAX_BLOCK_LETTERS)) u_ctrl (
        .aclk (aclk), .aresetn (aresetn),
        .in_valid (s_tvalid), .in_ready (s_tready),
        .in_char (s_tdata), .in_last (s_tlast),
        .block_length (len_reg),
        .cmd (cmd), .stat (stat), .base (base), .cipher (cipher),
        .out_valid (m_tvalid), .out_ready (m_tready),
        .out_plain (plain), .out_cipher (cipher_o), .out_bad (m_tuser)
    );

    rsab26_datapath #(.MODULUS_BITS(MODULUS_BITS)) u_dp (
        .aclk (aclk), .aresetn (aresetn),
        .cmd (cmd), .base (base), .exponent (exp_reg),
        .modulus (mod_reg[MODULUS_BITS-1:0]),
        .stat (stat), .cipher (cipher)
    );

    assign m_tdata = {3'b000, cipher_o, plain};

endmodule
